// File: rtl/fdef_pkg.sv
// ----------------------------------------------------------------------------
// fdef_pkg
// Types and constants shared by the FAT 8.3 directory entry filter.
// ----------------------------------------------------------------------------
package fdef_pkg;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_FOUND   = 2'd1;
  localparam logic [1:0] KIND_MISSING = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam logic [1:0] CFG_SEARCH_MODE = 2'd0;
  localparam logic [1:0] CFG_TARGET_NAME = 2'd1;
  localparam logic [1:0] CFG_TARGET_EXT  = 2'd2;

  localparam logic [7:0] MARK_DELETED   = 8'hE5;
  localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
  localparam int         ATTR_LABEL_BIT = 3;
  localparam int         ATTR_DIR_BIT   = 4;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_DOT         = 8'h2E;
  localparam logic [7:0] CH_LOWER_A     = 8'h61;
  localparam logic [7:0] CH_LOWER_Z     = 8'h7A;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  localparam logic [63:0] SPACES_8 = 64'h2020_2020_2020_2020;
  localparam logic [23:0] SPACES_3 = 24'h20_2020;

  // Twelve output slots: eight name bytes, the dot, three extension bytes
  localparam int NUM_SLOTS = 12;
  localparam int DOT_SLOT  = 8;

  typedef struct packed {
    logic [63:0] entry_base_name;
    logic [23:0] entry_extension;
    logic [7:0]  entry_attributes;
    logic [31:0] entry_first_cluster;
    logic [31:0] entry_size;
    logic [15:0] entry_position;
    logic        first_of_directory;
    logic        last_of_directory;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  name_byte;
    logic        is_directory;
    logic [31:0] file_size;
    logic [31:0] first_cluster;
    logic [15:0] result_position;
    logic        last_of_run;
  } out_item_t;

  // Work for the back end: bytes to list, then an optional closing result
  typedef struct packed {
    logic [NUM_SLOTS-1:0]      slot_mask;
    logic [NUM_SLOTS-1:0][7:0] slot_bytes;
    logic                      has_term;
    logic [1:0]                term_kind;
    logic                      is_dir;
    logic [31:0]               size;
    logic [31:0]               cluster;
    logic [15:0]               position;
  } desc_t;

endpackage

// File: rtl/fdef_front.sv
// ----------------------------------------------------------------------------
// fdef_front
// Classifies each directory entry, tracks the end of directory and turns the
// entry into a work descriptor for the back end.
// ----------------------------------------------------------------------------
module fdef_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fdef_pkg::in_item_t in_item,
  input  logic              search_mode,
  input  logic [63:0]       target_base_name,
  input  logic [23:0]       target_extension,
  output logic              push_valid,
  input  logic              push_ready,
  output fdef_pkg::desc_t   push_desc
);

  logic        finished_r, finished_nxt;
  logic [10:0][7:0] nm;
  logic [10:0][7:0] tg;
  logic [10:0] byte_eq;
  logic        finished_eff, skip, end_mark, same, dots, has_ext, list_it, accept;
  logic [1:0]  close_kind;
  logic [fdef_pkg::NUM_SLOTS-1:0] list_mask;
  fdef_pkg::desc_t desc;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      nm[i] = in_item.entry_base_name[8*i +: 8];
      tg[i] = target_base_name[8*i +: 8];
    end
    for (int i = 0; i < 3; i++) begin
      nm[8+i] = in_item.entry_extension[8*i +: 8];
      tg[8+i] = target_extension[8*i +: 8];
    end
    // case-folded compare, one byte lane each
    for (int i = 0; i < 11; i++) begin
      if (nm[i] >= fdef_pkg::CH_LOWER_A && nm[i] <= fdef_pkg::CH_LOWER_Z) begin
        byte_eq[i] = (nm[i] - fdef_pkg::CASE_OFFSET) == tg[i];
      end else begin
        byte_eq[i] = nm[i] == tg[i];
      end
    end
  end

  always_comb begin
    finished_eff = in_item.first_of_directory ? 1'b0 : finished_r;
    skip = (nm[0] == fdef_pkg::MARK_DELETED) ||
           (in_item.entry_attributes == fdef_pkg::ATTR_LONG_NAME) ||
           in_item.entry_attributes[fdef_pkg::ATTR_LABEL_BIT];
    end_mark = !skip && (nm[0] == 8'h00);
    same     = &byte_eq;
    dots     = (nm[0] == fdef_pkg::CH_DOT) &&
               ((nm[1] == fdef_pkg::CH_DOT) || (nm[1] == fdef_pkg::CH_SPACE)) &&
               (nm[2] == fdef_pkg::CH_SPACE);
    has_ext  = (nm[8] != fdef_pkg::CH_SPACE) || (nm[9] != fdef_pkg::CH_SPACE) ||
               (nm[10] != fdef_pkg::CH_SPACE);
    list_it  = !skip && !end_mark && !search_mode && !dots;
    close_kind = search_mode ? fdef_pkg::KIND_MISSING : fdef_pkg::KIND_DONE;

    for (int i = 0; i < 8; i++) begin
      list_mask[i] = nm[i] != fdef_pkg::CH_SPACE;
    end
    list_mask[fdef_pkg::DOT_SLOT] = has_ext;
    for (int i = 0; i < 3; i++) begin
      list_mask[fdef_pkg::DOT_SLOT+1+i] = nm[8+i] != fdef_pkg::CH_SPACE;
    end

    desc = '0;
    for (int i = 0; i < 8; i++) begin
      desc.slot_bytes[i] = nm[i];
    end
    desc.slot_bytes[fdef_pkg::DOT_SLOT] = fdef_pkg::CH_DOT;
    for (int i = 0; i < 3; i++) begin
      desc.slot_bytes[fdef_pkg::DOT_SLOT+1+i] = nm[8+i];
    end
    desc.is_dir   = in_item.entry_attributes[fdef_pkg::ATTR_DIR_BIT];
    desc.size     = desc.is_dir ? 32'd0 : in_item.entry_size;
    desc.cluster  = in_item.entry_first_cluster;
    desc.position = in_item.entry_position;

    finished_nxt = finished_eff;
    if (finished_eff) begin
      desc.has_term = 1'b0;
    end else if (end_mark) begin
      desc.has_term  = 1'b1;
      desc.term_kind = close_kind;
      finished_nxt   = 1'b1;
    end else if (!skip && search_mode && same) begin
      desc.has_term  = 1'b1;
      desc.term_kind = fdef_pkg::KIND_FOUND;
      finished_nxt   = 1'b1;
    end else begin
      desc.slot_mask = list_it ? list_mask : '0;
      desc.has_term  = in_item.last_of_directory;
      desc.term_kind = close_kind;
      finished_nxt   = in_item.last_of_directory;
    end
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && push_ready;
  // drop requests that give no result
  assign push_valid = in_valid && ((desc.slot_mask != '0) || desc.has_term);
  assign push_desc  = desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r <= 1'b0;
    end else if (accept) begin
      finished_r <= finished_nxt;
    end
  end

endmodule

// File: rtl/fdef_queue.sv
// ----------------------------------------------------------------------------
// fdef_queue
// Small descriptor queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module fdef_queue #(
  parameter int DEPTH = 2  // power of two, 2 to 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  fdef_pkg::desc_t push_desc,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fdef_pkg::desc_t pop_desc
);

  localparam int AW = $clog2(DEPTH);

  fdef_pkg::desc_t entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = count_r != (AW+1)'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_desc   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: rtl/fdef_back.sv
// ----------------------------------------------------------------------------
// fdef_back
// Result sequencer: walks a descriptor's listed bytes, then its closing
// result, one result per cycle into the output register while it is not held.
// ----------------------------------------------------------------------------
module fdef_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  fdef_pkg::desc_t   pop_desc,
  output logic              out_valid,
  input  logic              out_ready,
  output fdef_pkg::out_item_t out_item
);

  fdef_pkg::desc_t cur_r;
  logic            cur_valid_r;
  logic [fdef_pkg::NUM_SLOTS-1:0] rem_r, low, rem_after;
  logic [3:0]      idx;
  logic            advance, emit_byte, desc_done;
  logic            out_valid_r;
  fdef_pkg::out_item_t out_item_r, res;

  always_comb begin
    low       = rem_r & (~rem_r + 1'b1);
    rem_after = rem_r & ~low;
    idx       = '0;
    for (int i = fdef_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (low[i]) idx = 4'(i);
    end
    emit_byte = rem_r != '0;
    desc_done = emit_byte ? ((rem_after == '0) && !cur_r.has_term) : 1'b1;
    advance   = cur_valid_r && (!out_valid_r || out_ready);
    pop_ready = !cur_valid_r || (advance && desc_done);

    res = '0;
    res.last_of_run = desc_done;
    if (emit_byte) begin
      res.result_kind     = fdef_pkg::KIND_BYTE;
      res.name_byte       = cur_r.slot_bytes[idx];
      res.is_directory    = cur_r.is_dir;
      res.file_size       = cur_r.size;
      res.first_cluster   = cur_r.cluster;
      res.result_position = cur_r.position;
    end else begin
      res.result_kind = cur_r.term_kind;
      // only a match carries the entry's metadata
      if (cur_r.term_kind == fdef_pkg::KIND_FOUND) begin
        res.is_directory    = cur_r.is_dir;
        res.file_size       = cur_r.size;
        res.first_cluster   = cur_r.cluster;
        res.result_position = cur_r.position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_valid && pop_ready) begin
        cur_valid_r <= 1'b1;
      end else if (advance && desc_done) begin
        cur_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_desc;
      rem_r <= pop_desc.slot_mask;
    end else if (advance) begin
      rem_r <= rem_after;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/fat_directory_entry_filter_top.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_filter_top
// FAT 8.3 directory entry filter: lists entries as NAME.EXT bytes or
// searches a directory for a configured 8.3 name.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one directory entry per request (valid/ready).
//   out_* : result items (valid/ready); last_of_run marks the final result
//           of an entry. Entries that give no result produce nothing.
//   cfg_* : register writes (index 0 search mode, 1 target name, 2 target
//           extension), always ready; write only while the block is idle.
// Path: when the pipe is empty, an entry's descriptor is written into the
//   queue, loaded by the sequencer and its first result registered out.
// Throughput: one result per cycle at the output register while the output
//   is not held; an entry gives 1 to 13 results, walked by the sequencer.
//   Entries with no result never enter the queue.
// Reset: queue and output empty, end-of-directory mark cleared, search mode
//   off, target name and extension all spaces.
// Stall: a held output stalls the sequencer; the queue keeps taking
//   requests until it holds QUEUE_DEPTH descriptors, then in_ready drops.
// ----------------------------------------------------------------------------
module fat_directory_entry_filter_top #(
  parameter int QUEUE_DEPTH = 2  // power of two, 2 to 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fdef_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output fdef_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  logic        search_mode_r;
  logic [63:0] target_name_r;
  logic [23:0] target_ext_r;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  fdef_pkg::desc_t push_desc, pop_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_mode_r <= 1'b0;
      target_name_r <= fdef_pkg::SPACES_8;
      target_ext_r  <= fdef_pkg::SPACES_3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdef_pkg::CFG_SEARCH_MODE: search_mode_r <= cfg_data[0];
        fdef_pkg::CFG_TARGET_NAME: target_name_r <= cfg_data;
        fdef_pkg::CFG_TARGET_EXT:  target_ext_r  <= cfg_data[23:0];
        default: ;  // ignore writes beyond the register list
      endcase
    end
  end

  fdef_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .search_mode      (search_mode_r),
    .target_base_name (target_name_r),
    .target_extension (target_ext_r),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_desc        (push_desc)
  );

  fdef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  fdef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_desc  (pop_desc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FAT 8.3 directory entry filter. A directed set
// of entries and then random directories, in list and in search mode, are fed
// through the request channel. A built-in predictor works out the expected
// name bytes and found / not found / complete results. The monitor compares
// each result with the oldest expected one. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  fdef_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  fdef_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [63:0]         cfg_data;

  fat_directory_entry_filter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: register copies and the end-of-directory mark
  logic        search_on;
  logic [63:0] target_name;
  logic [23:0] target_ext;
  logic        dir_finished;

  fdef_pkg::in_item_t  entry_backlog [$];
  fdef_pkg::out_item_t expected_results [$];

  logic in_taken;
  logic no_idle;
  int   entries_queued;
  int   entries_accepted;
  int   directories;
  int   register_writes;
  int   mismatches;
  int   name_bytes_seen;
  int   found_seen;
  int   missing_seen;
  int   complete_seen;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Work out every result one entry causes, in order
  function automatic void predict_entry_results(fdef_pkg::in_item_t e);
    logic [7:0]          nm [11];
    logic [7:0]          tg [11];
    logic [7:0]          folded;
    fdef_pkg::out_item_t run [$];
    fdef_pkg::out_item_t r;
    fdef_pkg::out_item_t term;
    logic                is_dir;
    logic                same;
    logic                dots;
    logic                has_ext;
    logic [7:0]          attr;

    attr   = e.entry_attributes;
    is_dir = attr[fdef_pkg::ATTR_DIR_BIT];
    r = '0;
    r.result_kind     = fdef_pkg::KIND_BYTE;
    r.is_directory    = is_dir;
    r.file_size       = is_dir ? 32'd0 : e.entry_size;
    r.first_cluster   = e.entry_first_cluster;
    r.result_position = e.entry_position;
    term = '0;
    term.result_kind = search_on ? fdef_pkg::KIND_MISSING : fdef_pkg::KIND_DONE;

    if (e.first_of_directory) dir_finished = 1'b0;
    if (dir_finished) return;

    for (int i = 0; i < 8; i++) begin
      nm[i] = e.entry_base_name[8*i +: 8];
      tg[i] = target_name[8*i +: 8];
    end
    for (int i = 0; i < 3; i++) begin
      nm[8+i] = e.entry_extension[8*i +: 8];
      tg[8+i] = target_ext[8*i +: 8];
    end

    if (!(nm[0] == fdef_pkg::MARK_DELETED || attr == fdef_pkg::ATTR_LONG_NAME ||
          attr[fdef_pkg::ATTR_LABEL_BIT])) begin
      if (nm[0] == 8'h00) begin
        term.last_of_run = 1'b1;
        expected_results.push_back(term);
        dir_finished = 1'b1;
        return;
      end
      if (search_on) begin
        same = 1'b1;
        for (int i = 0; i < 11; i++) begin
          folded = (nm[i] >= fdef_pkg::CH_LOWER_A && nm[i] <= fdef_pkg::CH_LOWER_Z)
                   ? nm[i] - fdef_pkg::CASE_OFFSET : nm[i];
          if (folded != tg[i]) same = 1'b0;
        end
        if (same) begin
          r.result_kind = fdef_pkg::KIND_FOUND;
          r.last_of_run = 1'b1;
          expected_results.push_back(r);
          dir_finished = 1'b1;
          return;
        end
      end else begin
        dots = nm[0] == fdef_pkg::CH_DOT &&
               (nm[1] == fdef_pkg::CH_DOT || nm[1] == fdef_pkg::CH_SPACE) &&
               nm[2] == fdef_pkg::CH_SPACE;
        if (!dots) begin
          has_ext = nm[8] != fdef_pkg::CH_SPACE || nm[9] != fdef_pkg::CH_SPACE ||
                    nm[10] != fdef_pkg::CH_SPACE;
          for (int i = 0; i < 11; i++) begin
            if (i == fdef_pkg::DOT_SLOT && has_ext) begin
              r.name_byte = fdef_pkg::CH_DOT;
              run.push_back(r);
            end
            if (nm[i] != fdef_pkg::CH_SPACE) begin
              r.name_byte = nm[i];
              run.push_back(r);
            end
          end
        end
      end
    end

    if (e.last_of_directory) begin
      run.push_back(term);
      dir_finished = 1'b1;
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) expected_results.push_back(run[i]);
  endfunction

  // Space-padded 8.3 entry with random metadata
  function automatic fdef_pkg::in_item_t fat_entry(string base, string ext,
                                                   logic [7:0] attr, bit first, bit last);
    fdef_pkg::in_item_t e;
    e.entry_base_name = fdef_pkg::SPACES_8;
    e.entry_extension = fdef_pkg::SPACES_3;
    for (int i = 0; i < base.len() && i < 8; i++) e.entry_base_name[8*i +: 8] = base[i];
    for (int i = 0; i < ext.len() && i < 3; i++) e.entry_extension[8*i +: 8] = ext[i];
    e.entry_attributes    = attr;
    e.entry_first_cluster = $urandom;
    e.entry_size          = $urandom;
    e.entry_position      = 16'($urandom_range(16'hFFFF));
    e.first_of_directory  = first;
    e.last_of_directory   = last;
    return e;
  endfunction

  function automatic fdef_pkg::in_item_t random_name_entry();
    string              charset;
    fdef_pkg::in_item_t e;
    logic [7:0]         attr;
    int                 blen;
    int                 elen;
    charset = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_~-!abcxyz";
    attr = 8'($urandom_range(255));
    attr[fdef_pkg::ATTR_LABEL_BIT] = 1'b0;
    e = fat_entry("", "", attr, 1'b0, 1'b0);
    blen = $urandom_range(1, 8);
    elen = $urandom_range(0, 3);
    for (int i = 0; i < blen; i++)
      e.entry_base_name[8*i +: 8] = charset[$urandom_range(charset.len() - 1)];
    for (int i = 0; i < elen; i++)
      e.entry_extension[8*i +: 8] = charset[$urandom_range(charset.len() - 1)];
    return e;
  endfunction

  task automatic queue_entry(fdef_pkg::in_item_t e);
    entry_backlog.push_back(e);
    entries_queued++;
  endtask

  // Mostly well-formed directory with random content and some noise
  task automatic add_random_directory(int entries);
    fdef_pkg::in_item_t e;
    logic [191:0]       noise;
    logic [7:0]         b;
    int                 roll;
    directories++;
    for (int k = 0; k < entries; k++) begin
      roll = $urandom_range(99);
      e = random_name_entry();
      if (roll < 8) e.entry_base_name[7:0] = fdef_pkg::MARK_DELETED;
      else if (roll < 14) e.entry_attributes = fdef_pkg::ATTR_LONG_NAME;
      else if (roll < 19) e.entry_attributes[fdef_pkg::ATTR_LABEL_BIT] = 1'b1;
      else if (roll < 24) e = fat_entry($urandom_range(1) ? "." : "..", "", 8'h10, 1'b0, 1'b0);
      else if (roll < 27) e = fat_entry("", "", 8'h00, 1'b0, 1'b0);
      else if (roll < 33) begin
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        e = noise[$bits(fdef_pkg::in_item_t)-1:0];
      end else if (search_on && roll < 45) begin
        // Copy of the target with random lower-case letters
        e.entry_base_name = target_name;
        e.entry_extension = target_ext;
        for (int i = 0; i < 11; i++) begin
          b = (i < 8) ? e.entry_base_name[8*i +: 8] : e.entry_extension[8*(i-8) +: 8];
          if (b >= fdef_pkg::CH_LOWER_A - fdef_pkg::CASE_OFFSET &&
              b <= fdef_pkg::CH_LOWER_Z - fdef_pkg::CASE_OFFSET && $urandom_range(1))
            b = b + fdef_pkg::CASE_OFFSET;
          if (i < 8) e.entry_base_name[8*i +: 8] = b;
          else e.entry_extension[8*(i-8) +: 8] = b;
        end
      end
      if (roll >= 27 && roll < 33) begin
        if (k == 0) e.first_of_directory = 1'b1;
      end else begin
        e.first_of_directory = (k == 0) || ($urandom_range(99) < 3);
        e.last_of_directory  = 1'b0;
      end
      if (k == entries - 1 && $urandom_range(9) < 5) e.last_of_directory = 1'b1;
      queue_entry(e);
    end
    // Sometimes close with an end marker, followed by entries to drop
    if ($urandom_range(9) < 4) begin
      e = random_name_entry();
      e.entry_base_name[7:0] = 8'h00;
      queue_entry(e);
      roll = $urandom_range(2);
      for (int k = 0; k < roll; k++) queue_entry(random_name_entry());
    end
  endtask

  task automatic fill_random(int goal);
    int stop_at;
    stop_at = entries_queued + goal;
    while (entries_queued < stop_at) add_random_directory($urandom_range(1, 12));
  endtask

  // Hold until every request is taken and every result is back, then let
  // entries without results drain
  task automatic wait_idle();
    do @(posedge clk);
    while (entry_backlog.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    case (index)
      fdef_pkg::CFG_SEARCH_MODE: search_on   = value[0];
      fdef_pkg::CFG_TARGET_NAME: target_name = value;
      fdef_pkg::CFG_TARGET_EXT:  target_ext  = value[23:0];
      default: ;
    endcase
    register_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Request driver and ready generator
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (entry_backlog.size() > 0 && (no_idle || $urandom_range(99) >= 25)) begin
          in_item  <= entry_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      predict_entry_results(in_item);
      entries_accepted++;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    fdef_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      case (out_item.result_kind)
        fdef_pkg::KIND_BYTE:    name_bytes_seen++;
        fdef_pkg::KIND_FOUND:   found_seen++;
        fdef_pkg::KIND_MISSING: missing_seen++;
        default:                complete_seen++;
      endcase
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind=%0d byte=%h pos=%h", $realtime,
                   out_item.result_kind, out_item.name_byte, out_item.result_position);
      end else begin
        want = expected_results.pop_front();
        if (out_item.result_kind !== want.result_kind ||
            out_item.name_byte !== want.name_byte ||
            out_item.is_directory !== want.is_directory ||
            out_item.file_size !== want.file_size ||
            out_item.first_cluster !== want.first_cluster ||
            out_item.result_position !== want.result_position ||
            out_item.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch (kind byte dir size cluster pos last)", $realtime);
            $display("  expected %0d %h %b %h %h %h %b", want.result_kind, want.name_byte,
                     want.is_directory, want.file_size, want.first_cluster,
                     want.result_position, want.last_of_run);
            $display("  actual   %0d %h %b %h %h %h %b", out_item.result_kind,
                     out_item.name_byte, out_item.is_directory, out_item.file_size,
                     out_item.first_cluster, out_item.result_position, out_item.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    fdef_pkg::in_item_t e;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = fdef_pkg::CFG_SEARCH_MODE;
    cfg_data  = '0;
    in_taken  = 1'b0;
    no_idle   = 1'b0;
    search_on    = 1'b0;
    target_name  = fdef_pkg::SPACES_8;
    target_ext   = fdef_pkg::SPACES_3;
    dir_finished = 1'b0;
    entries_queued   = 0;
    entries_accepted = 0;
    directories      = 0;
    register_writes  = 0;
    mismatches       = 0;
    name_bytes_seen  = 0;
    found_seen       = 0;
    missing_seen     = 0;
    complete_seen    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // List mode from reset: every skip rule, dot entries, widest name
    e = fat_entry("README", "TXT", 8'h20, 1'b1, 1'b0);
    e.entry_size          = 32'hFFFF_FFFF;
    e.entry_first_cluster = 32'h0;
    e.entry_position      = 16'h0;
    queue_entry(e);
    e = fat_entry("DOCS", "", 8'h10, 1'b0, 1'b0);
    e.entry_size          = 32'hFFFF_FFFF;
    e.entry_first_cluster = 32'hFFFF_FFFF;
    e.entry_position      = 16'hFFFF;
    queue_entry(e);
    queue_entry(fat_entry(".", "", 8'h10, 1'b0, 1'b0));
    queue_entry(fat_entry("..", "", 8'h10, 1'b0, 1'b0));
    queue_entry(fat_entry(".X", "", 8'h10, 1'b0, 1'b0));
    e = fat_entry("XDELETED", "BAK", 8'h20, 1'b0, 1'b0);
    e.entry_base_name[7:0] = fdef_pkg::MARK_DELETED;
    queue_entry(e);
    e = fat_entry("LONGNAME", "", fdef_pkg::ATTR_LONG_NAME, 1'b0, 1'b0);
    e.entry_base_name[7:0] = 8'h00;
    queue_entry(e);
    queue_entry(fat_entry("VOLUME", "", 8'h08, 1'b0, 1'b0));
    queue_entry(fat_entry("", "", 8'h00, 1'b0, 1'b0));
    queue_entry(fat_entry("mixed", "c", 8'h00, 1'b0, 1'b0));
    queue_entry(fat_entry("ABCDEFGH", "IJK", 8'hFF & ~8'h08, 1'b0, 1'b1));
    queue_entry(fat_entry("A", "B", 8'h01, 1'b1, 1'b0));
    e = fat_entry("ZERO", "", 8'h00, 1'b0, 1'b0);
    e.entry_base_name[7:0] = 8'h00;
    queue_entry(e);
    queue_entry(fat_entry("IGNORED", "", 8'h00, 1'b0, 1'b0));
    queue_entry(fat_entry("IGNORED", "TOO", 8'h00, 1'b0, 1'b1));
    e = fat_entry("GONE", "", 8'h00, 1'b1, 1'b1);
    e.entry_base_name[7:0] = fdef_pkg::MARK_DELETED;
    queue_entry(e);
    directories += 3;
    fill_random(100);
    wait_idle();

    // Search mode
    write_register(fdef_pkg::CFG_SEARCH_MODE, 64'd1);
    write_register(fdef_pkg::CFG_TARGET_NAME, {"  LENREK"});
    write_register(fdef_pkg::CFG_TARGET_EXT, 64'h53_5953);
    queue_entry(fat_entry("OTHER", "TXT", 8'h20, 1'b1, 1'b0));
    queue_entry(fat_entry(".", "", 8'h10, 1'b0, 1'b0));
    queue_entry(fat_entry("kernel", "sys", 8'h21, 1'b0, 1'b0));
    queue_entry(fat_entry("KERNEL", "SYS", 8'h20, 1'b0, 1'b0));
    queue_entry(fat_entry("MISSING", "", 8'h00, 1'b1, 1'b1));
    e = fat_entry("ZERO", "", 8'h00, 1'b1, 1'b0);
    e.entry_base_name[7:0] = 8'h00;
    queue_entry(e);
    queue_entry(fat_entry("KERNEL", "SYS", 8'h10, 1'b1, 1'b1));
    queue_entry(fat_entry("KERNEL", "SYS", 8'h08, 1'b1, 1'b1));
    directories += 5;
    fill_random(50);
    // Hold the sender until the block has delivered everything
    wait_idle();
    fill_random(50);
    wait_idle();

    // Extreme targets: all ones, then all zeros
    write_register(fdef_pkg::CFG_TARGET_NAME, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(fdef_pkg::CFG_TARGET_EXT, 64'hFF_FFFF);
    e = fat_entry("", "", 8'h10, 1'b1, 1'b0);
    e.entry_base_name = 64'hFFFF_FFFF_FFFF_FFFF;
    e.entry_extension = 24'hFF_FFFF;
    queue_entry(e);
    directories++;
    fill_random(30);
    wait_idle();
    write_register(fdef_pkg::CFG_TARGET_NAME, 64'd0);
    write_register(fdef_pkg::CFG_TARGET_EXT, 64'd0);
    fill_random(20);
    wait_idle();

    // Back to list mode; first part runs without any idling
    write_register(fdef_pkg::CFG_SEARCH_MODE, 64'd0);
    no_idle = 1'b1;
    fill_random(40);
    wait_idle();
    no_idle = 1'b0;
    fill_random(30);
    wait_idle();

    if (expected_results.size() != 0) mismatches++;
    $display("Ran %0d entries in about %0d directories over %0d register writes,",
             entries_accepted, directories, register_writes);
    $display("checked %0d name bytes, %0d found, %0d not found, %0d complete; %0d mismatches",
             name_bytes_seen, found_seen, missing_seen, complete_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
